// ----- sv/pfvc_pkg.sv -----
`timescale 1ns / 1ps
package pfvc_pkg;
	localparam int CORDIC_ITERS = 16;
	localparam int IW = $clog2(CORDIC_ITERS + 1);
	localparam logic [47:0] SAT_CAP = 48'h7FFF_FFFF_FFFF;
	localparam logic [27:0] INV_GAIN_Q28 = 28'd163008219;
	localparam logic signed [39:0] HALF_PI_Q30 = 40'sd1686629713;

	typedef enum logic [2:0] {
		REG_GOAL_GAIN, REG_SPEED_GAIN, REG_TURN_GAIN, REG_SPEED_LIMIT,
		REG_TURN_LIMIT, REG_GRID_STEP, REG_ARRIVE_RADIUS, REG_NONE
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CORDIC, ST_DIST, ST_P, ST_GRAD, ST_SPD, ST_M, ST_A, ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MOP_NONE, MOP_SHIFT16, MOP_SHIFT13, MOP_DIST
	} mop_t;

	function automatic logic signed [39:0] atan_entry(input logic [IW-1:0] i);
		logic signed [39:0] r;
		unique case (i)
			0: r = 40'sd843314857;
			1: r = 40'sd497837829;
			2: r = 40'sd263043837;
			3: r = 40'sd133525159;
			4: r = 40'sd67021687;
			5: r = 40'sd33543516;
			6: r = 40'sd16775851;
			7: r = 40'sd8388437;
			8: r = 40'sd4194283;
			9: r = 40'sd2097149;
			default: r = (i > 30) ? 40'sd0 : (40'sd1 <<< 30) >>> i;
		endcase
		return r;
	endfunction
endpackage

// ----- sv/pfvc_cordic.sv -----
`timescale 1ns / 1ps
module pfvc_cordic import pfvc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [32:0] vx,
	input  logic signed [32:0] vy,
	output logic busy,
	output logic signed [39:0] mag,
	output logic signed [39:0] ang
);
	// Vectoring CORDIC, one micro-rotation per cycle through one adder pair.
	logic signed [39:0] x_q, y_q, z_q;
	logic [IW-1:0] it_q;
	logic run_q;
	logic signed [39:0] xs, ys;

	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign busy = run_q;
	assign mag = x_q;
	assign ang = z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			it_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			it_q <= '0;
		end else if (run_q) begin
			if (it_q == IW'(CORDIC_ITERS - 1)) run_q <= 1'b0;
			it_q <= it_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (vx < 0 && vy >= 0) begin
				x_q <= 40'(vy); y_q <= -40'(vx); z_q <= HALF_PI_Q30;
			end else if (vx < 0) begin
				x_q <= -40'(vy); y_q <= 40'(vx); z_q <= -HALF_PI_Q30;
			end else begin
				x_q <= 40'(vx); y_q <= 40'(vy); z_q <= '0;
			end
		end else if (run_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_entry(it_q);
			end else begin
				x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_entry(it_q);
			end
		end
	end
endmodule

// ----- sv/pfvc_mul.sv -----
`timescale 1ns / 1ps
module pfvc_mul import pfvc_pkg::*; (
	input  logic clk,
	input  mop_t op,
	input  logic [47:0] a,
	input  logic [35:0] b,
	output logic [47:0] r
);
	// Shared multiplier: a split into 24-bit halves, each multiplied by b.
	// Stage one registers both partial products; stage two sums, shifts and saturates.
	logic [59:0] hi_s1, lo_s1;
	mop_t op_s1;
	logic [84:0] full;
	logic [84:0] sh;

	always_ff @(posedge clk) begin
		hi_s1 <= a[47:24] * b;
		lo_s1 <= a[23:0] * b;
		op_s1 <= op;
	end

	always_comb begin
		full = {hi_s1, 24'd0} + 85'(lo_s1);
		unique case (op_s1)
			MOP_SHIFT16: sh = full >> 16;
			MOP_SHIFT13: sh = full >> 13;
			MOP_DIST:    sh = (full + 85'(1 << 27)) >> 28;
			default:     sh = full;
		endcase
	end

	always_ff @(posedge clk) r <= (sh > 85'(SAT_CAP)) ? SAT_CAP : sh[47:0];
endmodule

// ----- sv/potential_field_velocity_controller.sv -----
`timescale 1ns / 1ps
// Attractive potential field velocity controller.
// One input channel (valid/ready) carries mode, pos_x, pos_y and heading.
// A transaction with mode 1 stores the goal and arms the controller; it gives
// no result. A transaction with mode 0 is a pose tick: while armed, it gives
// one result transaction of linear_speed, angular_rate and arrived on the
// output channel; while disarmed it gives none.
// A tick runs one vectoring CORDIC of CORDIC_ITERS iterations, latches the
// bearing, then computes six products in turn on one shared two-stage
// multiplier before the result is valid.
// The block takes one transaction at a time; ready is low from acceptance of
// a tick until the result is taken, so a stalled receiver stalls the input.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// must only be made while the block is idle.
// Reset restores register defaults and disarms; the goal returns to zero.
module potential_field_velocity_controller import pfvc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] heading,
	output logic out_valid,
	input  logic out_ready,
	output logic [24:0] linear_speed,
	output logic signed [25:0] angular_rate,
	output logic arrived,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [24:0] cfg_data
);
	logic [24:0] goal_gain_q, speed_gain_q, turn_gain_q, speed_limit_q;
	logic [24:0] turn_limit_q, grid_step_q, arrive_radius_q;
	logic armed_q;
	logic signed [31:0] tx_q, ty_q;
	logic signed [15:0] hd_q;
	state_t st_q, st_d;
	logic [1:0] wait_q;
	logic [47:0] d_q, p_q, grad_q, spdraw_q, m_q;
	logic signed [15:0] dir_q;
	logic [24:0] spd_out_q;
	logic signed [25:0] rate_out_q;
	logic arr_q;

	logic start;
	logic cbusy;
	logic signed [39:0] cmag, cang;
	mop_t mop;
	logic [47:0] ma, mr;
	logic [35:0] mb;
	logic accept_tick;
	logic signed [16:0] err;
	logic [16:0] errmag;

	assign in_ready = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign linear_speed = spd_out_q;
	assign angular_rate = rate_out_q;
	assign arrived = arr_q;
	assign accept_tick = in_valid && in_ready && !mode && armed_q;
	assign start = accept_tick;

	pfvc_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(start),
		.vx(33'(tx_q) - 33'(pos_x)), .vy(33'(ty_q) - 33'(pos_y)),
		.busy(cbusy), .mag(cmag), .ang(cang)
	);

	pfvc_mul u_mul (.clk(clk), .op(mop), .a(ma), .b(mb), .r(mr));

	assign err = 17'(hd_q) - 17'(dir_q);
	assign errmag = err < 0 ? 17'(-err) : 17'(err);

	// Operand select for the shared multiplier by state.
	always_comb begin
		mop = MOP_NONE; ma = '0; mb = '0;
		unique case (st_q)
			ST_DIST: begin
				mop = MOP_DIST;
				ma = (cmag < 0) ? 48'd0 : 48'(cmag);
				mb = 36'(INV_GAIN_Q28);
			end
			ST_P:    begin mop = MOP_SHIFT16; ma = 48'(goal_gain_q); mb = 36'(grid_step_q); end
			ST_GRAD: begin mop = MOP_SHIFT16; ma = d_q; mb = 36'({p_q[34:0], 1'b0}); end
			ST_SPD:  begin mop = MOP_SHIFT16; ma = grad_q; mb = 36'(speed_gain_q); end
			ST_M:    begin mop = MOP_SHIFT16; ma = spdraw_q; mb = 36'(turn_gain_q); end
			ST_A:    begin mop = MOP_SHIFT13; ma = m_q; mb = 36'(errmag); end
			default: ;
		endcase
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (accept_tick) st_d = ST_CORDIC;
			ST_CORDIC: if (!cbusy) st_d = ST_DIST;
			ST_DIST: if (wait_q == 2'd2) st_d = ST_P;
			ST_P:    if (wait_q == 2'd2) st_d = ST_GRAD;
			ST_GRAD: if (wait_q == 2'd2) st_d = ST_SPD;
			ST_SPD:  if (wait_q == 2'd2) st_d = ST_M;
			ST_M:    if (wait_q == 2'd2) st_d = ST_A;
			ST_A:    if (wait_q == 2'd2) st_d = ST_OUT;
			ST_OUT:  if (out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			wait_q <= '0;
		end else begin
			st_q <= st_d;
			wait_q <= (st_d != st_q) ? 2'd0 : wait_q + ((wait_q == 2'd3) ? 2'd0 : 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_gain_q <= 25'd6554; speed_gain_q <= 25'd65536;
			turn_gain_q <= 25'd32768; speed_limit_q <= 25'd98304;
			turn_limit_q <= 25'd65536; grid_step_q <= 25'd32768;
			arrive_radius_q <= 25'd65536;
			armed_q <= 1'b0; tx_q <= '0; ty_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_GOAL_GAIN:     goal_gain_q <= cfg_data;
					REG_SPEED_GAIN:    speed_gain_q <= cfg_data;
					REG_TURN_GAIN:     turn_gain_q <= cfg_data;
					REG_SPEED_LIMIT:   speed_limit_q <= cfg_data;
					REG_TURN_LIMIT:    turn_limit_q <= cfg_data;
					REG_GRID_STEP:     grid_step_q <= cfg_data;
					REG_ARRIVE_RADIUS: arrive_radius_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready && mode) begin
				tx_q <= pos_x; ty_q <= pos_y; armed_q <= 1'b1;
			end else if (st_q == ST_A && wait_q == 2'd2 && d_q < 48'(arrive_radius_q)) begin
				armed_q <= 1'b0;
			end
		end
	end

	// Each product is captured once its operand has passed both multiplier registers.
	always_ff @(posedge clk) begin
		if (accept_tick) hd_q <= heading;
		if (st_q == ST_CORDIC && !cbusy)
			dir_q <= 16'((cang + 40'sd65536) >>> 17);
		if (wait_q == 2'd2) begin
			unique case (st_q)
				ST_DIST: d_q <= mr;
				ST_P:    p_q <= mr;
				ST_GRAD: grad_q <= mr;
				ST_SPD:  spdraw_q <= mr;
				ST_M:    m_q <= mr;
				ST_A: begin
					spd_out_q <= (spdraw_q > 48'(speed_limit_q)) ? speed_limit_q : spdraw_q[24:0];
					arr_q <= d_q < 48'(arrive_radius_q);
					if (mr > 48'(turn_limit_q))
						rate_out_q <= (err > 0) ? -26'(turn_limit_q) : 26'(turn_limit_q);
					else
						rate_out_q <= (err > 0) ? -26'(mr[24:0]) : 26'(mr[24:0]);
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !in_ready) else $error("ready while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(linear_speed)
		&& $stable(angular_rate))) else $error("result changed under stall");
	a_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angular_rate <= $signed({1'b0, turn_limit_q})
		&& angular_rate >= -$signed({1'b0, turn_limit_q}))) else $error("rate limit");
`endif
endmodule
